// File: rtl/core/phase_space_histogram_macros.svh
`ifndef PHASE_SPACE_HISTOGRAM_MACROS_SVH
`define PHASE_SPACE_HISTOGRAM_MACROS_SVH

// Checked on every clock edge outside reset.
`define PSH_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PSH_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/psh_pkg.sv
package psh_pkg;

  localparam int unsigned BINS_HALF_DEFAULT   = 64;
  localparam int unsigned COUNT_WIDTH_DEFAULT = 24;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic index;
    logic read;
    logic finish;
    logic zero;
    logic clear;
  } psh_ctl_t;

  typedef struct packed {
    op_t  op;
    logic clear_last;
  } psh_status_t;

endpackage

// File: rtl/core/phase_space_histogram.sv
// Channel   Handshake             Ports
// -------   -------------------   ------------------------------------------------
// command   start & !busy          command, position_q, momentum_q, read_pos_bin,
//                                  read_mom_bin, last_of_batch
// result    valid, one cycle       pos_bin, mom_bin, pos_count, mom_count,
//                                  joint_count, out_of_range, batch_end
//
// An add or read word gives its result on valid after the bin, index, memory read
// and update steps in sequence; the next word is taken only once that result is out,
// so a new word is not taken while the last one is still in work.
// A clear sweeps the joint store one entry a cycle over all (2*BINS_HALF+5)*(2*BINS_HALF+1)
// entries, and then gives its result; busy stays high throughout.
// After reset the same sweep runs with busy high and gives no result.
// The receiver cannot stall: every result is marked valid for exactly one cycle.
module phase_space_histogram #(
  parameter int unsigned BINS_HALF   = psh_pkg::BINS_HALF_DEFAULT,
  parameter int unsigned COUNT_WIDTH = psh_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             command,
  input  logic signed [16:0]     position_q,
  input  logic signed [17:0]     momentum_q,
  input  logic [7:0]             read_pos_bin,
  input  logic [7:0]             read_mom_bin,
  input  logic                   last_of_batch,
  output logic                   valid,
  output logic [7:0]             pos_bin,
  output logic [7:0]             mom_bin,
  output logic [COUNT_WIDTH-1:0] pos_count,
  output logic [COUNT_WIDTH-1:0] mom_count,
  output logic [COUNT_WIDTH-1:0] joint_count,
  output logic                   out_of_range,
  output logic                   batch_end
);
  import psh_pkg::*;

  psh_ctl_t    ctl;
  psh_status_t stat;

  psh_controller u_controller (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .valid (valid),
    .ctl   (ctl),
    .stat  (stat)
  );

  psh_datapath #(
    .BINS_HALF   (BINS_HALF),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .command       (command),
    .position_q    (position_q),
    .momentum_q    (momentum_q),
    .read_pos_bin  (read_pos_bin),
    .read_mom_bin  (read_mom_bin),
    .last_of_batch (last_of_batch),
    .pos_bin       (pos_bin),
    .mom_bin       (mom_bin),
    .pos_count     (pos_count),
    .mom_count     (mom_count),
    .joint_count   (joint_count),
    .out_of_range  (out_of_range),
    .batch_end     (batch_end)
  );

endmodule

// File: rtl/core/psh_datapath.sv
module psh_datapath #(
  parameter int unsigned BINS_HALF   = psh_pkg::BINS_HALF_DEFAULT,
  parameter int unsigned COUNT_WIDTH = psh_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  psh_pkg::psh_ctl_t      ctl,
  output psh_pkg::psh_status_t   stat,
  input  logic [1:0]             command,
  input  logic signed [16:0]     position_q,
  input  logic signed [17:0]     momentum_q,
  input  logic [7:0]             read_pos_bin,
  input  logic [7:0]             read_mom_bin,
  input  logic                   last_of_batch,
  output logic [7:0]             pos_bin,
  output logic [7:0]             mom_bin,
  output logic [COUNT_WIDTH-1:0] pos_count,
  output logic [COUNT_WIDTH-1:0] mom_count,
  output logic [COUNT_WIDTH-1:0] joint_count,
  output logic                   out_of_range,
  output logic                   batch_end
);
  import psh_pkg::*;

  localparam int unsigned POS_DEPTH   = 2 * BINS_HALF + 5;
  localparam int unsigned MOM_DEPTH   = 2 * BINS_HALF + 1;
  localparam int unsigned JOINT_DEPTH = POS_DEPTH * MOM_DEPTH;
  localparam int unsigned POS_AW      = $clog2(POS_DEPTH);
  localparam int unsigned MOM_AW      = $clog2(MOM_DEPTH);
  localparam int unsigned JOINT_AW    = $clog2(JOINT_DEPTH);
  localparam int unsigned NUM_W       = 26 + $clog2(BINS_HALF);
  localparam int unsigned Q_W         = NUM_W - 16;
  localparam int unsigned POS_OFFSET  = BINS_HALF * 65536 + 163840;
  localparam int unsigned MOM_OFFSET  = BINS_HALF * 65536 + 32768;
  localparam int unsigned BIN_MAX     = 255;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    bump = (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
  endfunction

  op_t                      op;
  logic signed [16:0]       xq;
  logic signed [17:0]       pq;
  logic [7:0]               rpb;
  logic [7:0]               rmb;

  logic signed [NUM_W-1:0]  pos_num;
  logic signed [NUM_W-1:0]  mom_num;
  logic [Q_W-1:0]           pos_qt;
  logic [Q_W-1:0]           mom_qt;
  logic [7:0]               pos_bin_next;
  logic [7:0]               mom_bin_next;
  logic [POS_AW-1:0]        pos_idx_next;
  logic [MOM_AW-1:0]        mom_idx_next;
  logic                     pos_ok_next;
  logic                     mom_ok_next;

  logic [7:0]               pos_bin_r;
  logic [7:0]               mom_bin_r;
  logic [POS_AW-1:0]        pos_idx;
  logic [MOM_AW-1:0]        mom_idx;
  logic                     pos_ok;
  logic                     mom_ok;
  logic [JOINT_AW-1:0]      joint_idx;
  logic [JOINT_AW-1:0]      cursor;

  logic [COUNT_WIDTH-1:0]   pos_mem [POS_DEPTH];
  logic [COUNT_WIDTH-1:0]   mom_mem [MOM_DEPTH];
  logic [COUNT_WIDTH-1:0]   joint_mem [JOINT_DEPTH];
  logic [COUNT_WIDTH-1:0]   pos_rd;
  logic [COUNT_WIDTH-1:0]   mom_rd;
  logic [COUNT_WIDTH-1:0]   joint_rd;

  logic                     in_rng;
  logic                     upd;
  logic                     pos_we;
  logic                     mom_we;
  logic                     joint_we;
  logic [POS_AW-1:0]        pos_waddr;
  logic [MOM_AW-1:0]        mom_waddr;
  logic [JOINT_AW-1:0]      joint_waddr;
  logic [COUNT_WIDTH-1:0]   pos_wdata;
  logic [COUNT_WIDTH-1:0]   mom_wdata;
  logic [COUNT_WIDTH-1:0]   joint_wdata;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op        <= op_t'(command);
      xq        <= position_q;
      pq        <= momentum_q;
      rpb       <= read_pos_bin;
      rmb       <= read_mom_bin;
      batch_end <= last_of_batch;
    end
  end

  always_comb begin
    pos_num = NUM_W'(xq) * $signed(NUM_W'(2 * BINS_HALF))
            + $signed(NUM_W'(POS_OFFSET));
    mom_num = NUM_W'(pq) * $signed(NUM_W'(BINS_HALF))
            + $signed(NUM_W'(MOM_OFFSET));
    pos_qt  = pos_num[NUM_W-1:16];
    mom_qt  = mom_num[NUM_W-1:16];
    if (op == OP_ADD) begin
      pos_ok_next  = !pos_num[NUM_W-1] && (pos_qt < Q_W'(POS_DEPTH));
      mom_ok_next  = !mom_num[NUM_W-1] && (mom_qt < Q_W'(MOM_DEPTH));
      pos_idx_next = POS_AW'(pos_qt);
      mom_idx_next = MOM_AW'(mom_qt);
      if (pos_num[NUM_W-1]) begin
        pos_bin_next = '0;
      end else if (pos_qt > Q_W'(BIN_MAX)) begin
        pos_bin_next = 8'(BIN_MAX);
      end else begin
        pos_bin_next = 8'(pos_qt);
      end
      if (mom_num[NUM_W-1]) begin
        mom_bin_next = '0;
      end else if (mom_qt > Q_W'(BIN_MAX)) begin
        mom_bin_next = 8'(BIN_MAX);
      end else begin
        mom_bin_next = 8'(mom_qt);
      end
    end else begin
      pos_ok_next  = 32'(rpb) < POS_DEPTH;
      mom_ok_next  = 32'(rmb) < MOM_DEPTH;
      pos_idx_next = POS_AW'(rpb);
      mom_idx_next = MOM_AW'(rmb);
      pos_bin_next = rpb;
      mom_bin_next = rmb;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      pos_bin_r <= pos_bin_next;
      mom_bin_r <= mom_bin_next;
      pos_idx   <= pos_idx_next;
      mom_idx   <= mom_idx_next;
      pos_ok    <= pos_ok_next;
      mom_ok    <= mom_ok_next;
    end
    if (ctl.index) begin
      joint_idx <= JOINT_AW'(pos_idx) * JOINT_AW'(MOM_DEPTH) + JOINT_AW'(mom_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
    end else if (ctl.clear) begin
      cursor <= stat.clear_last ? '0 : cursor + 1'b1;
    end
  end

  assign stat = '{op: op, clear_last: (cursor == JOINT_AW'(JOINT_DEPTH - 1))};

  assign in_rng = pos_ok && mom_ok;
  assign upd    = ctl.finish && (op == OP_ADD) && in_rng;

  always_comb begin
    pos_we      = upd || (ctl.clear && (32'(cursor) < POS_DEPTH));
    mom_we      = upd || (ctl.clear && (32'(cursor) < MOM_DEPTH));
    joint_we    = upd || ctl.clear;
    pos_waddr   = ctl.clear ? POS_AW'(cursor) : pos_idx;
    mom_waddr   = ctl.clear ? MOM_AW'(cursor) : mom_idx;
    joint_waddr = ctl.clear ? cursor : joint_idx;
    pos_wdata   = ctl.clear ? '0 : bump(pos_rd);
    mom_wdata   = ctl.clear ? '0 : bump(mom_rd);
    joint_wdata = ctl.clear ? '0 : bump(joint_rd);
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (ctl.read) begin
      pos_rd <= pos_mem[pos_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (mom_we) begin
      mom_mem[mom_waddr] <= mom_wdata;
    end
    if (ctl.read) begin
      mom_rd <= mom_mem[mom_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (joint_we) begin
      joint_mem[joint_waddr] <= joint_wdata;
    end
    if (ctl.read) begin
      joint_rd <= joint_mem[joint_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.zero) begin
      pos_bin      <= '0;
      mom_bin      <= '0;
      pos_count    <= '0;
      mom_count    <= '0;
      joint_count  <= '0;
      out_of_range <= 1'b0;
    end else if (ctl.finish) begin
      pos_bin      <= pos_bin_r;
      mom_bin      <= mom_bin_r;
      out_of_range <= !in_rng;
      if (op == OP_ADD) begin
        pos_count   <= in_rng ? bump(pos_rd) : '0;
        mom_count   <= in_rng ? bump(mom_rd) : '0;
        joint_count <= in_rng ? bump(joint_rd) : '0;
      end else begin
        pos_count   <= pos_ok ? pos_rd : '0;
        mom_count   <= mom_ok ? mom_rd : '0;
        joint_count <= in_rng ? joint_rd : '0;
      end
    end
  end

endmodule

// File: rtl/core/psh_controller.sv
`include "phase_space_histogram_macros.svh"

module psh_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 valid,
  output psh_pkg::psh_ctl_t    ctl,
  input  psh_pkg::psh_status_t stat
);
  import psh_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_BIN   = 7'b0000010,
    S_INDEX = 7'b0000100,
    S_READ  = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   reply;
  logic   reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

  always_comb begin
    state_next = state;
    reply_next = reply;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_BIN;
        end
      end
      S_BIN: begin
        ctl.calc = 1'b1;
        case (stat.op)
          OP_ADD, OP_READ: begin
            state_next = S_INDEX;
          end
          OP_CLEAR: begin
            reply_next = 1'b1;
            state_next = S_CLEAR;
          end
          default: begin
            ctl.zero   = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end
      S_INDEX: begin
        ctl.index  = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        ctl.read   = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        ctl.finish = 1'b1;
        state_next = S_DONE;
      end
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (stat.clear_last) begin
          reply_next = 1'b0;
          if (reply) begin
            ctl.zero   = 1'b1;
            state_next = S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy  = (state != S_IDLE);
  assign valid = (state == S_DONE);

  `PSH_ASSERT_ALWAYS(a_reset_clears, rst |=> (state == S_CLEAR), "reset must start a clear sweep")
  `PSH_ASSERT(a_valid_pulse, valid |=> !valid, "result strobe held longer than one cycle")
  `PSH_ASSERT(a_sweep_runs, (state == S_CLEAR && !stat.clear_last) |=> (state == S_CLEAR), "clear sweep left early")
  `PSH_ASSERT(a_write_then_result, (state == S_WRITE) |=> valid, "count update not followed by its result")

endmodule
